@@ sv/rac_pkg.sv @@
// shared constants, codes and the cordic angle table for the resolver angle block
package rac_pkg;

    // guard bits below the sample lsb inside the cordic datapath
    localparam int GUARD_BITS = 8;

    // cordic angle accumulator, a full turn is 2^Z_BITS
    localparam int Z_BITS = 32;

    // number of entries in the arctangent table
    localparam int TABLE_LEN = 24;

    // half a turn in accumulator units
    localparam logic [Z_BITS-1:0] HALF_TURN = 32'h8000_0000;

    // reset value of the travel limit before it is cut to the angle width
    localparam logic [15:0] BOUND_RESET_WORD = 16'hFFFF;

    // configuration register index
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SWAP   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_BOUND  = 2'd2
    } cfg_reg_t;

    // atan(2^-i) as a fraction of a full turn, rounded
    localparam logic [Z_BITS-1:0] TURN_ATAN [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

@@ sv/rac_if.sv @@
// valid/ready channel interfaces for sample sets and angle results

interface rac_sample_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_ref;
    logic [SAMPLE_BITS-1:0] sample_sine;
    logic [SAMPLE_BITS-1:0] sample_cosine;

    modport source (output valid, output sample_ref, output sample_sine,
                    output sample_cosine, input ready);
    modport sink (input valid, input sample_ref, input sample_sine,
                  input sample_cosine, output ready);
endinterface

interface rac_result_if #(
    parameter int ANGLE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] raw_angle;
    logic [ANGLE_BITS-1:0] calibrated_angle;
    logic [ANGLE_BITS-1:0] upper_bound;
    logic                  bound_grew;

    modport source (output valid, output raw_angle, output calibrated_angle,
                    output upper_bound, output bound_grew, input ready);
    modport sink (input valid, input raw_angle, input calibrated_angle,
                  input upper_bound, input bound_grew, output ready);
endinterface

@@ sv/rac_front.sv @@
// input stage: reference removal, sine/cosine swap and half-plane pre-rotation
module rac_front #(
    parameter int SAMPLE_BITS = 12,
    parameter int W           = 23
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rac_sample_if.sink           samples,
    input  logic                 swap,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic signed [W-1:0]  x,
    output logic signed [W-1:0]  y,
    output logic [31:0]          z,
    output logic                 zero
);
    import rac_pkg::*;

    logic                       valid_reg;
    logic signed [W-1:0]        x_reg;
    logic signed [W-1:0]        y_reg;
    logic [Z_BITS-1:0]          z_reg;
    logic                       zero_reg;

    logic signed [SAMPLE_BITS:0] sine_diff;
    logic signed [SAMPLE_BITS:0] cosine_diff;
    logic signed [SAMPLE_BITS:0] s_sel;
    logic signed [SAMPLE_BITS:0] c_sel;
    logic signed [W-1:0]         x_scaled;
    logic signed [W-1:0]         y_scaled;
    logic signed [W-1:0]         x_next;
    logic signed [W-1:0]         y_next;
    logic [Z_BITS-1:0]           z_next;
    logic                        zero_next;

    // subtract the reference, optionally trade sine and cosine
    always_comb
    begin
        sine_diff   = $signed({1'b0, samples.sample_sine}) - $signed({1'b0, samples.sample_ref});
        cosine_diff = $signed({1'b0, samples.sample_cosine})
                      - $signed({1'b0, samples.sample_ref});
        s_sel       = swap ? cosine_diff : sine_diff;
        c_sel       = swap ? sine_diff : cosine_diff;
        zero_next   = (s_sel == '0) && (c_sel == '0);
        x_scaled    = W'(c_sel) <<< GUARD_BITS;
        y_scaled    = W'(s_sel) <<< GUARD_BITS;
    end

    // fold the left half plane onto the right one
    always_comb
    begin
        if (x_scaled < 0)
        begin
            x_next = -x_scaled;
            y_next = -y_scaled;
            z_next = HALF_TURN;
        end
        else
        begin
            x_next = x_scaled;
            y_next = y_scaled;
            z_next = '0;
        end
    end

    assign samples.ready = !valid_reg || dn_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            valid_reg <= samples.valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_next;
        end
    end

    assign dn_valid = valid_reg;
    assign x        = x_reg;
    assign y        = y_reg;
    assign z        = z_reg;
    assign zero     = zero_reg;

endmodule

@@ sv/rac_cordic_stage.sv @@
// one registered vectoring cordic micro-rotation
module rac_cordic_stage #(
    parameter int W    = 23,
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    input  logic [31:0]         z_in,
    input  logic                zero_in,
    output logic                dn_valid,
    input  logic                dn_ready,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] y_out,
    output logic [31:0]         z_out,
    output logic                zero_out
);
    import rac_pkg::*;

    logic                valid_reg;
    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic [Z_BITS-1:0]   z_reg;
    logic                zero_reg;

    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] x_next;
    logic signed [W-1:0] y_next;
    logic [Z_BITS-1:0]   z_next;

    // rotate towards the x axis, direction from the sign of y
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + TURN_ATAN[STEP];
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - TURN_ATAN[STEP];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_in;
        end
    end

    assign dn_valid = valid_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign zero_out = zero_reg;

endmodule

@@ sv/rac_track.sv @@
// output stage: angle rounding, offset removal, travel bound tracking
module rac_track #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [31:0]           z,
    input  logic                  zero,
    input  logic [ANGLE_BITS-1:0] offset,
    input  logic                  bound_load,
    input  logic [ANGLE_BITS-1:0] bound_value,
    rac_result_if.source          results
);
    import rac_pkg::*;

    localparam logic [Z_BITS-1:0]     ROUND_HALF  = Z_BITS'(1) << (Z_BITS - 1 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] BOUND_RESET = ANGLE_BITS'(BOUND_RESET_WORD);

    logic                  out_valid_reg;
    logic [ANGLE_BITS-1:0] raw_reg;
    logic [ANGLE_BITS-1:0] cal_reg;
    logic [ANGLE_BITS-1:0] bound_reg;
    logic                  grew_reg;
    logic [ANGLE_BITS-1:0] tracked_reg;
    logic [ANGLE_BITS-1:0] tracked_next;

    logic [Z_BITS-1:0]     z_rounded;
    logic [ANGLE_BITS-1:0] raw_next;
    logic [ANGLE_BITS-1:0] cal_next;
    logic                  grew_next;
    logic                  take;

    // round the turn fraction to the angle width, then remove the offset
    always_comb
    begin
        z_rounded = z + ROUND_HALF;
        raw_next  = zero ? '0 : z_rounded[Z_BITS-1 -: ANGLE_BITS];
        cal_next  = raw_next - offset;
        grew_next = cal_next > tracked_reg;
    end

    assign up_ready = !out_valid_reg || results.ready;
    assign take     = up_ready && up_valid;

    // bound follows the largest calibrated angle, reloaded by configuration
    always_comb
    begin
        tracked_next = tracked_reg;
        if (bound_load)
        begin
            tracked_next = bound_value;
        end
        else if (take && grew_next)
        begin
            tracked_next = cal_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tracked_reg   <= BOUND_RESET;
        end
        else
        begin
            tracked_reg <= tracked_next;
            if (up_ready)
            begin
                out_valid_reg <= up_valid;
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            raw_reg   <= raw_next;
            cal_reg   <= cal_next;
            bound_reg <= grew_next ? cal_next : tracked_reg;
            grew_reg  <= grew_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.raw_angle        = raw_reg;
    assign results.calibrated_angle = cal_reg;
    assign results.upper_bound      = bound_reg;
    assign results.bound_grew       = grew_reg;

    // bound only moves down through a configuration load
    a_bound_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !bound_load |=> tracked_reg >= $past(tracked_reg))
        else $error("tracked bound fell without a load");

    // a word that reports growth carries its own angle as the bound
    a_grew_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && grew_reg) |-> (bound_reg == cal_reg))
        else $error("grown bound differs from calibrated angle");

    // reported bound never sits below the reported angle
    a_bound_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (bound_reg >= cal_reg))
        else $error("reported bound below calibrated angle");

endmodule

@@ sv/resolver_angle_calibrated_core.sv @@
// resolver angle block: reference removal, cordic atan2, offset and travel bound
//
// samples: one word per sine/cosine sensor reading (reference, sine, cosine
// adc samples), taken when valid and ready are both high.
// results: one word per sample set with the raw angle, the calibrated
// angle, the tracked upper bound and a flag telling that this word raised it.
// cfg_we/cfg_index/cfg_data write the swap bit, the zero offset and the
// initial upper bound; writing the bound also reloads the tracked bound.
// Write configuration only while no words are in flight.
// The word enters the input stage at the accepting edge, then passes one
// register per cordic micro-rotation and the output stage. Throughput is
// one word per cycle while the result receiver keeps taking words, with up
// to CORDIC_STEPS + 2 words held inside. Reset empties the pipeline, clears
// swap and offset and sets the tracked bound to all ones. When the result
// receiver stalls, words back up stage by stage and the sample channel
// drops ready once every stage is full.
module resolver_angle_calibrated_core #(
    parameter int SAMPLE_BITS  = 12,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rac_sample_if.sink                     samples,
    rac_result_if.source                   results,
    input  logic                           cfg_we,
    input  logic [rac_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ANGLE_BITS-1:0]          cfg_data
);
    import rac_pkg::*;

    // datapath width: sample, sign, guard bits and cordic growth
    localparam int W = SAMPLE_BITS + GUARD_BITS + 3;

    logic                  swap_reg;
    logic [ANGLE_BITS-1:0] offset_reg;
    logic                  bound_load;

    logic                valid_pipe [CORDIC_STEPS+1];
    logic                ready_pipe [CORDIC_STEPS+1];
    logic signed [W-1:0] x_pipe     [CORDIC_STEPS+1];
    logic signed [W-1:0] y_pipe     [CORDIC_STEPS+1];
    logic [Z_BITS-1:0]   z_pipe     [CORDIC_STEPS+1];
    logic                zero_pipe  [CORDIC_STEPS+1];

    // configuration decode
    always_comb
    begin
        bound_load = 1'b0;
        unique case (cfg_reg_t'(cfg_index))
            CFG_BOUND: bound_load = cfg_we;
            default:   bound_load = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SWAP:   swap_reg   <= cfg_data[0];
                CFG_OFFSET: offset_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // input stage
    rac_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .W           (W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .swap     (swap_reg),
        .dn_valid (valid_pipe[0]),
        .dn_ready (ready_pipe[0]),
        .x        (x_pipe[0]),
        .y        (y_pipe[0]),
        .z        (z_pipe[0]),
        .zero     (zero_pipe[0])
    );

    // cordic micro-rotations, one register each
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        rac_cordic_stage #(
            .W    (W),
            .STEP (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_pipe[i]),
            .up_ready (ready_pipe[i]),
            .x_in     (x_pipe[i]),
            .y_in     (y_pipe[i]),
            .z_in     (z_pipe[i]),
            .zero_in  (zero_pipe[i]),
            .dn_valid (valid_pipe[i+1]),
            .dn_ready (ready_pipe[i+1]),
            .x_out    (x_pipe[i+1]),
            .y_out    (y_pipe[i+1]),
            .z_out    (z_pipe[i+1]),
            .zero_out (zero_pipe[i+1])
        );
    end

    // output stage
    rac_track #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (valid_pipe[CORDIC_STEPS]),
        .up_ready    (ready_pipe[CORDIC_STEPS]),
        .z           (z_pipe[CORDIC_STEPS]),
        .zero        (zero_pipe[CORDIC_STEPS]),
        .offset      (offset_reg),
        .bound_load  (bound_load),
        .bound_value (cfg_data),
        .results     (results)
    );

endmodule

@@ sim/tb_top.sv @@
// testbench for the resolver angle block, directed and random words checked by a predictor
`timescale 1ns / 100ps

module tb_top;

    import rac_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int REPORT_LIMIT = 10;

    // index outside the register map, writes to it must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ANGLE_BITS-1:0]  angle_t;

    typedef struct packed {
        angle_t raw;
        angle_t cal;
        angle_t bound;
        logic   grew;
    } angle_word_t;

    typedef struct packed {
        sample_t     r;
        sample_t     s;
        sample_t     c;
        logic        typed;
        angle_word_t want;
    } sample_row_t;

    localparam angle_word_t ZERO_VEC_WORD = '{raw: '0, cal: '0, bound: '1, grew: 1'b0};
    localparam angle_word_t NO_WORD       = '0;

    // directed words, all at reset settings; the zero vectors have their answer typed in
    localparam sample_row_t DIRECTED_ROWS [21] = '{
        '{12'd0,    12'd0,    12'd0,    1'b1, ZERO_VEC_WORD},
        '{12'd4095, 12'd4095, 12'd4095, 1'b1, ZERO_VEC_WORD},
        '{12'd2048, 12'd2048, 12'd2048, 1'b1, ZERO_VEC_WORD},
        '{12'd2048, 12'd2048, 12'd4095, 1'b0, NO_WORD},
        '{12'd2048, 12'd2048, 12'd0,    1'b0, NO_WORD},
        '{12'd2048, 12'd4095, 12'd2048, 1'b0, NO_WORD},
        '{12'd2048, 12'd0,    12'd2048, 1'b0, NO_WORD},
        '{12'd0,    12'd4095, 12'd4095, 1'b0, NO_WORD},
        '{12'd4095, 12'd0,    12'd0,    1'b0, NO_WORD},
        '{12'd0,    12'd0,    12'd4095, 1'b0, NO_WORD},
        '{12'd0,    12'd4095, 12'd0,    1'b0, NO_WORD},
        '{12'd4095, 12'd4095, 12'd0,    1'b0, NO_WORD},
        '{12'd4095, 12'd0,    12'd4095, 1'b0, NO_WORD},
        '{12'd2048, 12'd2049, 12'd2048, 1'b0, NO_WORD},
        '{12'd2048, 12'd2047, 12'd2048, 1'b0, NO_WORD},
        '{12'd2048, 12'd2048, 12'd2049, 1'b0, NO_WORD},
        '{12'd2048, 12'd2048, 12'd2047, 1'b0, NO_WORD},
        '{12'd2048, 12'd3000, 12'd3000, 1'b0, NO_WORD},
        '{12'd2048, 12'd1000, 12'd3000, 1'b0, NO_WORD},
        '{12'd2048, 12'd1000, 12'd1000, 1'b0, NO_WORD},
        '{12'd2048, 12'd3000, 12'd1000, 1'b0, NO_WORD}
    };

    localparam sample_t RAIL_CODES [3] = '{12'd0, 12'd2048, 12'd4095};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    angle_t cfg_data;

    rac_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    rac_result_if #(.ANGLE_BITS(ANGLE_BITS))   angle_ch ();

    // predictor copy of the settings and the tracked bound
    logic   exp_swap;
    angle_t exp_offset;
    angle_t exp_tracked;

    angle_word_t pending_angles [$];
    int unsigned fail_count = 0;
    int unsigned sender_gap_pct = 0;
    int unsigned receiver_gap_pct = 0;
    logic rx_hold = 1'b0;
    event rx_hold_go;

    resolver_angle_calibrated_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .ANGLE_BITS(ANGLE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(sample_ch),
        .results(angle_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // angle of one sample set, advancing the tracked bound
    function automatic angle_word_t predict_angle_word(input sample_t r, input sample_t s,
                                                       input sample_t c);
        longint signed sd;
        longint signed cd;
        longint signed x;
        longint signed y;
        longint signed dx;
        longint signed dy;
        logic [Z_BITS-1:0] z;
        angle_word_t w;
        sd = longint'(s) - longint'(r);
        cd = longint'(c) - longint'(r);
        if (exp_swap)
        begin
            x = sd;
            y = cd;
        end
        else
        begin
            x = cd;
            y = sd;
        end
        if (x == 0 && y == 0)
        begin
            w.raw = '0;
        end
        else
        begin
            x = x * (longint'(1) << GUARD_BITS);
            y = y * (longint'(1) << GUARD_BITS);
            z = '0;
            // left half plane: rotate by half a turn first
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + TURN_ATAN[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - TURN_ATAN[i];
                end
            end
            // round to nearest at the angle width, wrap is free
            z = z + (32'd1 << (Z_BITS - 1 - ANGLE_BITS));
            w.raw = z[Z_BITS-1 -: ANGLE_BITS];
        end
        w.cal = w.raw - exp_offset;
        w.grew = 1'b0;
        if (w.cal > exp_tracked)
        begin
            exp_tracked = w.cal;
            w.grew = 1'b1;
        end
        w.bound = exp_tracked;
        return w;
    endfunction

    // offer one word, wait for it to be taken, then log the expected angle word
    task automatic send_set(input sample_t r, input sample_t s, input sample_t c,
                            input logic typed, input angle_word_t typed_word);
        angle_word_t w;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.sample_ref    <= r;
        sample_ch.sample_sine   <= s;
        sample_ch.sample_cosine <= c;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        w = predict_angle_word(r, s, c);
        if (typed)
        begin
            w = typed_word;
        end
        pending_angles.push_back(w);
    endtask

    // stop offering and wait until every angle word is back
    task automatic drain_angles();
        sample_ch.valid <= 1'b0;
        while (pending_angles.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one register write, held for a single edge
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input angle_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SWAP:   exp_swap = data[0];
            CFG_OFFSET: exp_offset = data;
            CFG_BOUND:  exp_tracked = data;
            default:    ;
        endcase
    endtask

    // load all three registers with the block idle
    task automatic load_settings(input angle_t swap_word, input angle_t offset,
                                 input angle_t bound);
        drain_angles();
        write_reg(CFG_SWAP, swap_word);
        write_reg(CFG_OFFSET, offset);
        write_reg(CFG_SPARE, angle_t'($urandom));
        write_reg(CFG_BOUND, bound);
        cfg_we <= 1'b0;
    endtask

    // random sample set: full range in four picks of ten, else small vectors, axes, rails or zero vectors
    task automatic pick_sample_set(output sample_t r, output sample_t s, output sample_t c);
        int unsigned kind;
        kind = $urandom_range(9);
        r = sample_t'($urandom);
        s = sample_t'($urandom);
        c = sample_t'($urandom);
        case (kind) inside
            [4:6]:
            begin
                r = sample_t'($urandom_range(16, 4079));
                s = sample_t'(int'(r) + int'($urandom_range(16)) - 8);
                c = sample_t'(int'(r) + int'($urandom_range(16)) - 8);
            end
            7:
            begin
                if ($urandom_range(1) == 0)
                    s = r;
                else
                    c = r;
            end
            8:
            begin
                r = RAIL_CODES[$urandom_range(2)];
                s = RAIL_CODES[$urandom_range(2)];
                c = RAIL_CODES[$urandom_range(2)];
            end
            9:
            begin
                s = r;
                c = r;
            end
            default: ;
        endcase
    endtask

    task automatic run_random_words(input int count);
        sample_t r;
        sample_t s;
        sample_t c;
        for (int n = 0; n < count; n++)
        begin
            pick_sample_set(r, s, c);
            send_set(r, s, c, 1'b0, NO_WORD);
        end
    endtask

    // receiver ready, random stalls plus the long hold-off
    initial
    begin
        angle_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            angle_ch.ready <= !rx_hold && ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(rx_hold_go);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // compare each returned word with the oldest expectation
    always @(posedge clk)
    begin : angle_check
        angle_word_t want;
        angle_word_t got;
        if (rst_n && angle_ch.valid && angle_ch.ready)
        begin
            got = {angle_ch.raw_angle, angle_ch.calibrated_angle, angle_ch.upper_bound,
                   angle_ch.bound_grew};
            if (pending_angles.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected angle word: raw %h cal %h bound %h grew %b",
                             got.raw, got.cal, got.bound, got.grew);
            end
            else
            begin
                want = pending_angles.pop_front();
                if (got != want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("angle word mismatch: want %h %h %h %b, got %h %h %h %b",
                                 want.raw, want.cal, want.bound, want.grew,
                                 got.raw, got.cal, got.bound, got.grew);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_SWAP;
        cfg_data                = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.sample_ref    = '0;
        sample_ch.sample_sine   = '0;
        sample_ch.sample_cosine = '0;
        exp_swap                = 1'b0;
        exp_offset              = '0;
        exp_tracked             = BOUND_RESET_WORD[ANGLE_BITS-1:0];
        sender_gap_pct          = 22;
        receiver_gap_pct        = 52;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset settings
        foreach (DIRECTED_ROWS[k])
        begin
            send_set(DIRECTED_ROWS[k].r, DIRECTED_ROWS[k].s, DIRECTED_ROWS[k].c,
                     DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        end

        // swapped inputs, upper data bits set, bound from zero so it grows
        load_settings(16'hFFFF, 16'h4000, 16'h0000);
        run_random_words(95);

        // other idling split, offset at its top, long receiver hold-off
        sender_gap_pct   = 52;
        receiver_gap_pct = 22;
        load_settings(16'hFFFE, 16'hFFFF, 16'h8000);
        run_random_words(30);
        -> rx_hold_go;
        run_random_words(65);

        // no idling, swap on, offset zero, bound at its top
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        load_settings(16'h0001, 16'h0000, 16'hFFFF);
        run_random_words(95);

        // random settings, with a pause until everything is back
        load_settings(angle_t'($urandom), angle_t'($urandom), angle_t'($urandom));
        run_random_words(50);
        drain_angles();
        run_random_words(50);

        // wait for the tail, then a little longer for strays
        sample_ch.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && pending_angles.size() != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (CORDIC_STEPS + 6) @(posedge clk);
        if (pending_angles.size() != 0)
        begin
            fail_count++;
            $display("%0d angle words never returned", pending_angles.size());
        end

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
